[sv/sacl_pkg.sv]
// Shared types and constants of the cache tag and replacement controller.
// Used by sacl_way_select and set_assoc_cache_tag_lru_controller_unit.
`timescale 1ns / 1ps
`default_nettype none

package sacl_pkg;

    localparam int DATA_W    = 32;
    localparam int WAY_IDX_W = 4;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_STORE = 1'b1
    } t_cmd;

    typedef struct packed {
        logic                 hit;
        logic                 writeback;
        logic [WAY_IDX_W-1:0] way;
    } t_sacl_dec;

    typedef struct packed {
        logic              pad;
        logic [DATA_W-1:0] store_data;
        logic [DATA_W-1:0] victim_block_address;
        logic              writeback_needed;
        logic              fill_needed;
        logic [5:0]        byte_offset;
        logic [3:0]        set_index;
        logic [1:0]        way_used;
        logic              hit;
    } t_sacl_out_beat;

endpackage

`default_nettype wire

[sv/sacl_way_select.sv]
// Tag compare, way choice and recency rank update for one set.
// Depends on sacl_pkg for the decision struct.
`timescale 1ns / 1ps
`default_nettype none

module sacl_way_select
    import sacl_pkg::*;
#(
    parameter int NUM_WAYS = 4,
    parameter int WAY_W    = 2,
    parameter int TAG_W    = 22
) (
    input  wire logic [TAG_W-1:0]                i_tag,
    input  wire logic [NUM_WAYS-1:0][TAG_W-1:0]  i_tag_row,
    input  wire logic [NUM_WAYS-1:0]             i_valid,
    input  wire logic [NUM_WAYS-1:0]             i_dirty,
    input  wire logic [NUM_WAYS-1:0][WAY_W-1:0]  i_rank,
    output t_sacl_dec                            o_dec,
    output logic [NUM_WAYS-1:0][WAY_W-1:0]       o_rank_next
);

    logic             w_hit;
    logic             w_any_inv;
    logic [WAY_W-1:0] w_hit_way;
    logic [WAY_W-1:0] w_inv_way;
    logic [WAY_W-1:0] w_lru_way;
    logic [WAY_W-1:0] w_way;
    logic [WAY_W-1:0] w_old_rank;

    always_comb begin
        w_hit     = 1'b0;
        w_any_inv = 1'b0;
        w_hit_way = '0;
        w_inv_way = '0;
        w_lru_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (i_valid[w] && (i_tag_row[w] == i_tag)) begin
                w_hit     = 1'b1;
                w_hit_way = WAY_W'(w);
            end
            if (!i_valid[w]) begin
                w_any_inv = 1'b1;
                w_inv_way = WAY_W'(w);
            end
            if (i_rank[w] == '0) begin
                w_lru_way = WAY_W'(w);
            end
        end
    end

    always_comb begin
        if (w_hit) begin
            w_way = w_hit_way;
        end else if (w_any_inv) begin
            w_way = w_inv_way;
        end else begin
            w_way = w_lru_way;
        end
        o_dec.hit       = w_hit;
        o_dec.writeback = !w_hit && !w_any_inv && i_dirty[w_lru_way];
        o_dec.way       = WAY_IDX_W'(w_way);
    end

    // The touched way becomes the most recent; ranks above its old rank move down.
    always_comb begin
        w_old_rank = i_rank[w_way];
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (WAY_W'(w) == w_way) begin
                o_rank_next[w] = WAY_W'(NUM_WAYS - 1);
            end else if (i_rank[w] > w_old_rank) begin
                o_rank_next[w] = i_rank[w] - 1'b1;
            end else begin
                o_rank_next[w] = i_rank[w];
            end
        end
    end

endmodule

`default_nettype wire

[sv/set_assoc_cache_tag_lru_controller_unit.sv]
// Top level of the set-associative write-back cache tag and LRU controller.
// Depends on sacl_pkg and sacl_way_select.
//
// The slave stream carries one access per beat: tuser holds the command
// (load or store) and tdata holds the byte address and the store word. The
// master stream returns one result beat per access with the hit flag, the
// way used, set and byte offset, fill and writeback flags, the victim block
// address and the echoed command and store word.
// Tags live in one synchronous memory and valid, dirty and recency ranks in
// a second one, one row per set. An accepted beat reads both rows into
// registers; the lookup state then decides the way and writes the metadata
// row back, and the tag row on a miss. The result is registered and offered
// on the master stream, and no new beat is accepted until the access has left
// the lookup state.
// After reset the metadata memory is cleared one set per cycle, and
// s_axis_tready stays low until every set is cleared.
// A waiting result does not block the next beat from being accepted. When
// the receiver stalls with a result still held, the following access waits
// in its lookup cycle and no state is written until its result can be stored.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_cache_tag_lru_controller_unit
    import sacl_pkg::*;
#(
    parameter int NUM_SETS    = 16,
    parameter int NUM_WAYS    = 4,
    parameter int BLOCK_BYTES = 64,
    parameter int ADDR_BITS   = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [31:0] address, [63:32] write_data
    input  wire logic [63:0]  s_axis_tdata,
    // [0] command
    input  wire logic [0:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [0] hit, [2:1] way_used, [6:3] set_index, [12:7] byte_offset,
    // [13] fill_needed, [14] writeback_needed, [46:15] victim_block_address,
    // [78:47] store_data, [79] zero
    output logic [79:0]       m_axis_tdata,
    // [0] is_store
    output logic [0:0]        m_axis_tuser
);

    localparam int EFF_A     = (ADDR_BITS < DATA_W) ? ADDR_BITS : DATA_W;
    localparam int OFF_W     = $clog2(BLOCK_BYTES);
    localparam int SET_BITS  = $clog2(NUM_SETS);
    localparam int SET_IDX_W = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int WAY_W     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int TAG_RAW   = EFF_A - OFF_W - SET_BITS;
    localparam int TAG_W     = (TAG_RAW > 0) ? TAG_RAW : 1;

    typedef struct packed {
        logic [NUM_WAYS-1:0]            valid;
        logic [NUM_WAYS-1:0]            dirty;
        logic [NUM_WAYS-1:0][WAY_W-1:0] rank;
    } t_meta;

    typedef logic [NUM_WAYS-1:0][TAG_W-1:0] t_tag_row;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    t_tag_row r_tag_mem [NUM_SETS];
    t_meta    r_meta_mem [NUM_SETS];

    t_state               r_state;
    logic [SET_IDX_W-1:0] r_clr_idx;
    t_tag_row             r_tag_rd;
    t_meta                r_meta_rd;
    logic                 r_cmd;
    logic [SET_IDX_W-1:0] r_set;
    logic [TAG_W-1:0]     r_tag;
    logic [OFF_W-1:0]     r_off;
    logic [DATA_W-1:0]    r_wdata;
    logic                 r_out_valid;
    t_sacl_out_beat       r_out;
    logic                 r_out_cmd;

    logic [EFF_A-1:0]               w_addr;
    logic [EFF_A-1:0]               w_blk;
    logic [SET_IDX_W-1:0]           w_set;
    logic [TAG_W-1:0]               w_tag;
    logic                           w_in_acc;
    logic                           w_out_free;
    logic                           w_commit;
    t_sacl_dec                      w_dec;
    logic [WAY_W-1:0]               w_way;
    logic [NUM_WAYS-1:0][WAY_W-1:0] w_rank_next;
    t_meta                          w_meta_upd;
    t_meta                          w_meta_rst;
    t_tag_row                       w_tag_upd;
    logic [EFF_A-1:0]               w_victim;
    t_sacl_out_beat                 w_beat;
    logic                           w_meta_we;
    logic [SET_IDX_W-1:0]           w_meta_wa;
    t_meta                          w_meta_wd;

    assign w_addr = s_axis_tdata[EFF_A-1:0];
    assign w_blk  = w_addr >> OFF_W;
    assign w_set  = SET_IDX_W'(w_blk & EFF_A'(NUM_SETS - 1));
    assign w_tag  = TAG_W'(w_blk >> SET_BITS);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_commit      = (r_state == ST_LOOKUP) && w_out_free;

    sacl_way_select #(
        .NUM_WAYS (NUM_WAYS),
        .WAY_W    (WAY_W),
        .TAG_W    (TAG_W)
    ) u_way_select (
        .i_tag       (r_tag),
        .i_tag_row   (r_tag_rd),
        .i_valid     (r_meta_rd.valid),
        .i_dirty     (r_meta_rd.dirty),
        .i_rank      (r_meta_rd.rank),
        .o_dec       (w_dec),
        .o_rank_next (w_rank_next)
    );

    assign w_way = w_dec.way[WAY_W-1:0];

    always_comb begin
        w_meta_rst.valid = '0;
        w_meta_rst.dirty = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            w_meta_rst.rank[w] = WAY_W'(w);
        end
    end

    always_comb begin
        w_meta_upd       = r_meta_rd;
        w_meta_upd.rank  = w_rank_next;
        w_meta_upd.valid[w_way] = 1'b1;
        if (w_dec.hit) begin
            w_meta_upd.dirty[w_way] = r_meta_rd.dirty[w_way] || (r_cmd == CMD_STORE);
        end else begin
            w_meta_upd.dirty[w_way] = (r_cmd == CMD_STORE);
        end
        w_tag_upd        = r_tag_rd;
        w_tag_upd[w_way] = r_tag;
    end

    always_comb begin
        w_victim = '0;
        if (w_dec.writeback) begin
            w_victim = ((EFF_A'(r_tag_rd[w_way]) << SET_BITS) | EFF_A'(r_set)) << OFF_W;
        end
        w_beat.pad                  = 1'b0;
        w_beat.store_data           = r_wdata;
        w_beat.victim_block_address = DATA_W'(w_victim);
        w_beat.writeback_needed     = w_dec.writeback;
        w_beat.fill_needed          = !w_dec.hit;
        w_beat.byte_offset          = 6'(r_off);
        w_beat.set_index            = 4'(r_set);
        w_beat.way_used             = 2'(w_way);
        w_beat.hit                  = w_dec.hit;
    end

    always_comb begin
        w_meta_we = 1'b0;
        w_meta_wa = r_set;
        w_meta_wd = w_meta_upd;
        if (w_commit) begin
            w_meta_we = 1'b1;
        end else if (r_state == ST_CLEAR) begin
            w_meta_we = 1'b1;
            w_meta_wa = r_clr_idx;
            w_meta_wd = w_meta_rst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_tag_rd  <= r_tag_mem[w_set];
            r_meta_rd <= r_meta_mem[w_set];
        end
        if (w_commit && !w_dec.hit) begin
            r_tag_mem[r_set] <= w_tag_upd;
        end
        if (w_meta_we) begin
            r_meta_mem[w_meta_wa] <= w_meta_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == SET_IDX_W'(NUM_SETS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= ST_LOOKUP;
                    end
                end
                ST_LOOKUP: begin
                    if (w_commit) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_in_acc) begin
            r_cmd   <= s_axis_tuser[0];
            r_set   <= w_set;
            r_tag   <= w_tag;
            r_off   <= w_addr[OFF_W-1:0];
            r_wdata <= s_axis_tdata[63:32];
        end
        if (w_commit) begin
            r_out     <= w_beat;
            r_out_cmd <= r_cmd;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out;
    assign m_axis_tuser[0] = r_out_cmd;

`ifndef NO_ASSERTIONS
    a_accept_enters_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == ST_LOOKUP))
        else $error("accepted beat did not enter lookup");

    a_stall_holds_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOKUP) && !w_out_free |=> (r_state == ST_LOOKUP))
        else $error("lookup left while result register was full");

    a_fill_is_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.fill_needed != r_out.hit))
        else $error("fill flag disagrees with hit flag");

    a_writeback_only_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.writeback_needed |-> !r_out.hit)
        else $error("writeback reported on a hit");

    a_victim_zero_when_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.writeback_needed |-> (r_out.victim_block_address == '0))
        else $error("victim address set without writeback");
`endif

endmodule

`default_nettype wire
